[rtl/srvr_pkg.sv]
// ----------------------------------------------------------------------------
// srvr_pkg
// Shared types and constants of the servo ramp controller.
// ----------------------------------------------------------------------------
package srvr_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 2;
  localparam int unsigned MAX_ANGLE_DEF    = 180;

  localparam int unsigned POS_RESET_FIRST  = 25;
  localparam int unsigned POS_RESET_OTHER  = 90;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned ANGLE_W = 11;
  localparam int unsigned DEG_W   = 8;
  localparam int unsigned PULSE_W = 16;
  localparam int unsigned PPD_W   = 10;
  localparam int unsigned TICK_W  = 16;

  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;

  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 16'd1638;
  localparam logic [PPD_W-1:0]   PPD_RST       = 10'd36;
  localparam logic [TICK_W-1:0]  STEP_DELAY_RST = 16'd10;
  localparam logic [TICK_W-1:0]  LOCKOUT_RST   = 16'd1000;

  // pairs of results held between the command stage and the output register
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_RAMP = 2'd1,
    OP_SET  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_PULSE_MIN  = 2'd0,
    REG_PPD        = 2'd1,
    REG_STEP_DELAY = 2'd2,
    REG_LOCKOUT    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [DEG_W-1:0] deg;
    logic             att;
  } res_rec_t;

  typedef struct packed {
    logic     two;
    res_rec_t r1;
    res_rec_t r0;
  } res_pair_t;

  typedef struct packed {
    logic [TICK_W-1:0] step_delay;
    logic [TICK_W-1:0] lockout;
  } motion_cfg_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_min;
    logic [PPD_W-1:0]   ppd;
  } pulse_cfg_t;

endpackage

[rtl/srvr_cmd_if.sv]
// ----------------------------------------------------------------------------
// srvr_cmd_if
// Command channel: opcode, channel and requested angle.
// ----------------------------------------------------------------------------
interface srvr_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [srvr_pkg::OP_W-1:0]          opcode;
  logic [srvr_pkg::CH_W-1:0]          channel;
  logic signed [srvr_pkg::ANGLE_W-1:0] angle;

  modport source (output valid, opcode, channel, angle, input ready);
  modport sink   (input valid, opcode, channel, angle, output ready);
endinterface

[rtl/srvr_res_if.sv]
// ----------------------------------------------------------------------------
// srvr_res_if
// Result channel: channel, pulse width, attachment and last marker.
// ----------------------------------------------------------------------------
interface srvr_res_if;
  logic                          valid;
  logic                          ready;
  logic [srvr_pkg::CH_W-1:0]     out_channel;
  logic [srvr_pkg::PULSE_W-1:0]  pulse_width;
  logic                          attached;
  logic                          last;

  modport source (output valid, out_channel, pulse_width, attached, last, input ready);
  modport sink   (input valid, out_channel, pulse_width, attached, last, output ready);
endinterface

[rtl/srvr_core.sv]
// ----------------------------------------------------------------------------
// srvr_core
// Command register, per-channel servo state and result pair generation.
// ----------------------------------------------------------------------------
module srvr_core #(
  parameter int unsigned NUM_CHANNELS = srvr_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_ANGLE    = srvr_pkg::MAX_ANGLE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  srvr_cmd_if.sink              cmd,
  input  logic                  space,
  input  srvr_pkg::motion_cfg_t cfg,
  output logic                  busy,
  output logic                  push,
  output srvr_pkg::res_pair_t   pair
);
  import srvr_pkg::*;

  // the channel field reaches three channels at most
  localparam int unsigned NCH = (NUM_CHANNELS < 3) ? NUM_CHANNELS : 3;

  logic              in_valid;
  op_t               in_op;
  logic [CH_W-1:0]   in_ch;
  logic [DEG_W-1:0]  in_deg;
  logic [DEG_W-1:0]  deg_clamped;
  logic              accept;

  logic [DEG_W-1:0]  position          [NCH];
  logic [DEG_W-1:0]  position_next     [NCH];
  logic [DEG_W-1:0]  target_angle      [NCH];
  logic [DEG_W-1:0]  target_angle_next [NCH];
  logic              moving            [NCH];
  logic              moving_next       [NCH];
  logic              attached          [NCH];
  logic              attached_next     [NCH];
  logic [TICK_W-1:0] since_set         [NCH];
  logic [TICK_W-1:0] since_set_next    [NCH];
  logic [TICK_W-1:0] step_timer        [NCH];
  logic [TICK_W-1:0] step_timer_next   [NCH];

  assign cmd.ready = space;
  assign accept    = cmd.valid & cmd.ready;
  assign busy      = in_valid;

  always_comb begin
    if (cmd.angle[ANGLE_W-1]) begin
      deg_clamped = '0;
    end else if (cmd.angle[ANGLE_W-2:0] > (ANGLE_W-1)'(MAX_ANGLE)) begin
      deg_clamped = DEG_W'(MAX_ANGLE);
    end else begin
      deg_clamped = cmd.angle[DEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    if (accept) begin
      in_op  <= op_t'(cmd.opcode);
      in_ch  <= cmd.channel;
      in_deg <= deg_clamped;
    end
  end

  always_comb begin
    logic [1:0]        n;
    logic [TICK_W-1:0] t;
    logic [TICK_W-1:0] d;
    res_rec_t          rec;
    n    = '0;
    t    = '0;
    rec  = '0;
    pair = '0;
    d    = (cfg.step_delay == '0) ? TICK_W'(1) : cfg.step_delay;
    for (int i = 0; i < NCH; i++) begin
      position_next[i]     = position[i];
      target_angle_next[i] = target_angle[i];
      moving_next[i]       = moving[i];
      attached_next[i]     = attached[i];
      since_set_next[i]    = since_set[i];
      step_timer_next[i]   = step_timer[i];
    end
    if (in_valid) begin
      case (in_op)
        OP_TICK: begin
          // channels served in ascending order, at most two steps per tick
          for (int i = 0; i < NCH; i++) begin
            if (since_set[i] != '1) begin
              since_set_next[i] = since_set[i] + TICK_W'(1);
            end
            if (moving[i]) begin
              t = (step_timer[i] != '1) ? step_timer[i] + TICK_W'(1) : step_timer[i];
              if (t >= d && n < 2'd2) begin
                step_timer_next[i] = '0;
                if (position[i] < target_angle[i]) begin
                  position_next[i] = position[i] + DEG_W'(1);
                end else if (position[i] > target_angle[i]) begin
                  position_next[i] = position[i] - DEG_W'(1);
                end
                if (position_next[i] == target_angle[i]) begin
                  moving_next[i]    = 1'b0;
                  attached_next[i]  = 1'b0;
                  since_set_next[i] = '0;
                end
                rec.ch  = CH_W'(i + 1);
                rec.deg = position_next[i];
                rec.att = attached_next[i];
                if (n == 2'd0) begin
                  pair.r0 = rec;
                end else begin
                  pair.r1 = rec;
                end
                n = n + 2'd1;
              end else begin
                step_timer_next[i] = t;
              end
            end
          end
        end
        OP_RAMP: begin
          for (int i = 0; i < NCH; i++) begin
            if (in_ch == CH_W'(i + 1) && !moving[i] && since_set[i] >= cfg.lockout) begin
              attached_next[i] = 1'b1;
              pair.r0.ch  = in_ch;
              pair.r0.deg = position[i];
              pair.r0.att = 1'b1;
              n = 2'd1;
              if (position[i] == in_deg) begin
                // already there: report attach then detach
                attached_next[i]  = 1'b0;
                since_set_next[i] = '0;
                pair.r1.ch  = in_ch;
                pair.r1.deg = in_deg;
                pair.r1.att = 1'b0;
                n = 2'd2;
              end else begin
                target_angle_next[i] = in_deg;
                moving_next[i]       = 1'b1;
                step_timer_next[i]   = '0;
              end
            end
          end
        end
        OP_SET: begin
          for (int i = 0; i < NCH; i++) begin
            if (in_ch == CH_W'(i + 1)) begin
              moving_next[i]     = 1'b0;
              step_timer_next[i] = '0;
              position_next[i]   = in_deg;
              since_set_next[i]  = '0;
              pair.r0.ch  = in_ch;
              pair.r0.deg = in_deg;
              pair.r0.att = attached[i];
              n = 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    push     = (n != 2'd0);
    pair.two = (n == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCH; i++) begin
        position[i]     <= (i == 0) ? DEG_W'(POS_RESET_FIRST) : DEG_W'(POS_RESET_OTHER);
        target_angle[i] <= '0;
        moving[i]       <= 1'b0;
        attached[i]     <= 1'b1;
        since_set[i]    <= '0;
        step_timer[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < NCH; i++) begin
        position[i]     <= position_next[i];
        target_angle[i] <= target_angle_next[i];
        moving[i]       <= moving_next[i];
        attached[i]     <= attached_next[i];
        since_set[i]    <= since_set_next[i];
        step_timer[i]   <= step_timer_next[i];
      end
    end
  end

endmodule

[rtl/srvr_out.sv]
// ----------------------------------------------------------------------------
// srvr_out
// Result pair queue, pulse width calculation and result register.
// ----------------------------------------------------------------------------
module srvr_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  srvr_pkg::res_pair_t  pair,
  input  logic                 pend,
  input  srvr_pkg::pulse_cfg_t cfg,
  output logic                 space,
  srvr_res_if.source           res
);
  import srvr_pkg::*;

  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned PROD_W = DEG_W + PPD_W;

  res_pair_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               sel;
  res_pair_t          head;
  res_rec_t           rec;
  logic               load;
  logic               is_last;
  logic               pop;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    sum;
  logic [PULSE_W-1:0] pulse;

  // room is kept for the request still in the command stage
  assign space = ({1'b0, count} + (CNT_W+1)'(pend)) < (CNT_W+1)'(FIFO_DEPTH);

  assign head    = mem[rd_ptr];
  assign rec     = sel ? head.r1 : head.r0;
  assign is_last = sel | ~head.two;
  assign load    = (count != '0) && (!res.valid || res.ready);
  assign pop     = load & is_last;

  assign prod  = PROD_W'(rec.deg) * PROD_W'(cfg.ppd);
  assign sum   = {1'b0, prod} + (PROD_W+1)'(cfg.pulse_min);
  assign pulse = (sum > (PROD_W+1)'({PULSE_W{1'b1}})) ? '1 : sum[PULSE_W-1:0];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= pair;
    end
    if (load) begin
      res.out_channel <= rec.ch;
      res.pulse_width <= pulse;
      res.attached    <= rec.att;
      res.last        <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      sel       <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
      if (load) begin
        sel <= ~is_last;
      end
      if (load) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CNT_W'(FIFO_DEPTH)))
    else $error("result pair written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("result pair removed from an empty queue");

  a_pend_room: assert property (@(posedge clk) disable iff (rst)
    pend |-> (count < CNT_W'(FIFO_DEPTH)))
    else $error("no room left for the request in the command stage");

  a_second_half: assert property (@(posedge clk) disable iff (rst)
    (load && !is_last) |=> (sel && count != '0))
    else $error("second result of a pair lost");

endmodule

[rtl/servo_ramp_controller_unit.sv]
// ----------------------------------------------------------------------------
// servo_ramp_controller_unit
// Servo pulse-width controller with slew-rate-limited ramped moves.
// ----------------------------------------------------------------------------
// A command (tick, ramped move or forced set) is accepted every cycle while
// the result queue has room; it is registered, decoded against the channel
// state in the next cycle, and its zero, one or two results go into a queue
// of four result pairs. The output register then presents one result per
// cycle while the receiver is ready, so commands that give one result run at
// one per cycle and those that give two run slower, limited by the output
// register. A result passes the command register, the queue and the output
// register. Pulse width is degrees times pulse_per_degree plus pulse_minimum,
// saturated to 16 bits, worked out as a result enters the output register.
// Registers sit on the APB port at byte addresses 0, 4, 8 and 12. They must
// be written by the user only while no command is in progress, unchecked.
module servo_ramp_controller_unit #(
  parameter int unsigned NUM_CHANNELS = srvr_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_ANGLE    = srvr_pkg::MAX_ANGLE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  srvr_cmd_if.sink                      cmd,
  srvr_res_if.source                    res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [srvr_pkg::APB_AW-1:0]   paddr,
  input  logic [srvr_pkg::APB_DW-1:0]   pwdata,
  output logic [srvr_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import srvr_pkg::*;

  logic [PULSE_W-1:0] pulse_minimum;
  logic [PPD_W-1:0]   pulse_per_degree;
  logic [TICK_W-1:0]  step_delay_ticks;
  logic [TICK_W-1:0]  lockout_ticks;
  reg_idx_t           reg_idx;
  logic               wr_en;

  motion_cfg_t        motion_cfg;
  pulse_cfg_t         pulse_cfg;
  logic               space;
  logic               busy;
  logic               push;
  res_pair_t          pair;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_minimum    <= PULSE_MIN_RST;
      pulse_per_degree <= PPD_RST;
      step_delay_ticks <= STEP_DELAY_RST;
      lockout_ticks    <= LOCKOUT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PULSE_MIN:  pulse_minimum    <= pwdata[PULSE_W-1:0];
        REG_PPD:        pulse_per_degree <= pwdata[PPD_W-1:0];
        REG_STEP_DELAY: step_delay_ticks <= pwdata[TICK_W-1:0];
        REG_LOCKOUT:    lockout_ticks    <= pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PULSE_MIN:  prdata = APB_DW'(pulse_minimum);
      REG_PPD:        prdata = APB_DW'(pulse_per_degree);
      REG_STEP_DELAY: prdata = APB_DW'(step_delay_ticks);
      REG_LOCKOUT:    prdata = APB_DW'(lockout_ticks);
      default:        prdata = '0;
    endcase
  end

  assign motion_cfg.step_delay = step_delay_ticks;
  assign motion_cfg.lockout    = lockout_ticks;
  assign pulse_cfg.pulse_min   = pulse_minimum;
  assign pulse_cfg.ppd         = pulse_per_degree;

  srvr_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_ANGLE    (MAX_ANGLE)
  ) u_core (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .space (space),
    .cfg   (motion_cfg),
    .busy  (busy),
    .push  (push),
    .pair  (pair)
  );

  srvr_out u_out (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pair  (pair),
    .pend  (busy),
    .cfg   (pulse_cfg),
    .space (space),
    .res   (res)
  );

endmodule
